// ----- rtl/core/daa_pkg.sv -----
// Shared types and constants for the digraph adjacency analyzer.
// No dependencies; imported by the analyzer top level.
`default_nettype none

package daa_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int VTX_W            = 7;
  localparam int MAP_W            = 64;

  localparam logic REQ_ADD_EDGE = 1'b0;
  localparam logic REQ_ANALYZE  = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [VTX_W-1:0] edge_src;
    logic [VTX_W-1:0] edge_dst;
  } daa_req_t;

  typedef struct packed {
    logic [VTX_W-1:0] vertex;
    logic [MAP_W-1:0] out_neighbours;
    logic [MAP_W-1:0] mutual_neighbours;
    logic [VTX_W-1:0] out_degree;
    logic [VTX_W-1:0] in_degree;
    logic             has_loop;
    logic             is_isolated;
    logic             reaches_all;
    logic             last;
  } daa_res_t;

endpackage

`default_nettype wire

// ----- rtl/core/daa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module daa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/digraph_adjacency_analyzer_unit.sv -----
// Digraph adjacency analyzer: edge load into row/column RAMs, per-vertex analysis sweep.
// An add-edge request reads its row and column on acceptance, then holds busy while the
// ORed row and column are written back. An analyze request over N vertices sends each
// vertex through the RAM read, s2 and output registers at one result per cycle; busy drops
// after the last. Reset: synchronous, active low; per-row valid flags clear the matrix.
// Results are strobed for one cycle; the receiver cannot stall.
`default_nettype none

module digraph_adjacency_analyzer_unit #(
  parameter int MAX_VERTICES = daa_pkg::MAX_VERTICES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire daa_pkg::daa_req_t in_req,
  output logic                   out_valid,
  output daa_pkg::daa_res_t      out_res
);

  import daa_pkg::*;

  // Address width of the row and column RAMs.
  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam logic [VTX_W-1:0] MAX_V = VTX_W'(MAX_VERTICES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EDGE_WR,
    ST_SWEEP,
    ST_DRAIN
  } state_t;

  state_t                  state_r;
  logic [VTX_W-1:0]        vcount_r;
  logic [AW-1:0]           idx_r;
  logic                    out_valid_r;
  daa_res_t                out_res_r;

  // Per-row valid flags: a row never written reads as zero.
  logic [MAX_VERTICES-1:0] row_vld_r;
  logic [MAX_VERTICES-1:0] col_vld_r;
  logic                    row_rvld_r;
  logic                    col_rvld_r;

  // Pending edge write-back.
  logic [AW-1:0]           row_waddr_r;
  logic [AW-1:0]           col_waddr_r;
  logic [MAX_VERTICES-1:0] row_bit_r;
  logic [MAX_VERTICES-1:0] col_bit_r;

  // Sweep pipeline: s1 = RAM data out, s2 = partial counts.
  logic                    s1_vld_r;
  logic [AW-1:0]           s1_idx_r;
  logic                    s1_last_r;
  logic                    s2_vld_r;
  logic [VTX_W-1:0]        s2_vtx_r;
  logic                    s2_last_r;
  logic [MAP_W-1:0]        s2_row_r;
  logic [MAP_W-1:0]        s2_mutual_r;
  logic                    s2_loop_r;
  logic                    s2_iso_r;
  logic [7:0][3:0]         s2_rcnt_r;
  logic [7:0][3:0]         s2_ccnt_r;

  logic [MAX_VERTICES-1:0] row_rdata;
  logic [MAX_VERTICES-1:0] col_rdata;
  logic [MAX_VERTICES-1:0] row_cur;
  logic [MAX_VERTICES-1:0] col_cur;
  logic [MAP_W-1:0]        row64;
  logic [MAP_W-1:0]        col64;
  logic [MAP_W-1:0]        self64;

  logic                    accept;
  logic                    is_edge;
  logic [VTX_W-1:0]        src_m1;
  logic [VTX_W-1:0]        dst_m1;
  logic                    edge_ok;
  logic [VTX_W-1:0]        vcount_nxt;
  logic [VTX_W-1:0]        vc_tmp;
  logic                    issue;
  logic [AW-1:0]           sweep_idx;
  logic                    issue_last;
  logic [AW-1:0]           row_raddr;
  logic [AW-1:0]           col_raddr;
  logic                    edge_we;
  logic [VTX_W-1:0]        od_sum;
  logic [VTX_W-1:0]        id_sum;

  function automatic logic [3:0] popcnt8(input logic [7:0] b);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(b[i]);
    end
    return n;
  endfunction

  function automatic logic [VTX_W-1:0] sum8(input logic [7:0][3:0] p);
    logic [VTX_W-1:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + VTX_W'(p[i]);
    end
    return n;
  endfunction

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign is_edge   = (in_req.req_type == REQ_ADD_EDGE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // Decode the edge: both ends must be 1..MAX_VERTICES.
  assign src_m1  = in_req.edge_src - VTX_W'(1);
  assign dst_m1  = in_req.edge_dst - VTX_W'(1);
  assign edge_ok = (in_req.edge_src != '0) && (in_req.edge_dst != '0) &&
                   (in_req.edge_src <= MAX_V) && (in_req.edge_dst <= MAX_V);

  always_comb begin
    vc_tmp     = (in_req.edge_src > vcount_r) ? in_req.edge_src : vcount_r;
    vcount_nxt = (in_req.edge_dst > vc_tmp) ? in_req.edge_dst : vc_tmp;
  end

  // Sweep read issue: vertex 0 on the analyze request, then one vertex per cycle.
  assign sweep_idx  = (state_r == ST_SWEEP) ? idx_r : '0;
  assign issue      = (accept && !is_edge && (vcount_r != '0)) || (state_r == ST_SWEEP);
  assign issue_last = (VTX_W'(sweep_idx) == (vcount_r - VTX_W'(1)));

  assign row_raddr = (state_r == ST_IDLE && is_edge) ? src_m1[AW-1:0] : sweep_idx;
  assign col_raddr = (state_r == ST_IDLE && is_edge) ? dst_m1[AW-1:0] : sweep_idx;

  // Mask rows that were never written since reset.
  assign row_cur = row_rdata & {MAX_VERTICES{row_rvld_r}};
  assign col_cur = col_rdata & {MAX_VERTICES{col_rvld_r}};
  assign edge_we = (state_r == ST_EDGE_WR);

  assign row64  = MAP_W'(row_cur);
  assign col64  = MAP_W'(col_cur);
  assign self64 = MAP_W'(1) << s1_idx_r;

  daa_ram #(
    .WIDTH (MAX_VERTICES),
    .DEPTH (MAX_VERTICES)
  ) u_row_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (row_waddr_r),
    .wdata (row_cur | row_bit_r),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  daa_ram #(
    .WIDTH (MAX_VERTICES),
    .DEPTH (MAX_VERTICES)
  ) u_col_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (col_waddr_r),
    .wdata (col_cur | col_bit_r),
    .raddr (col_raddr),
    .rdata (col_rdata)
  );

  assign od_sum = sum8(s2_rcnt_r);
  assign id_sum = sum8(s2_ccnt_r);

  // Control state machine and registered result outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vcount_r    <= '0;
      idx_r       <= '0;
      row_vld_r   <= '0;
      col_vld_r   <= '0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_vld_r    <= issue;
      s2_vld_r    <= s1_vld_r;
      out_valid_r <= s2_vld_r;
      if (s2_vld_r) begin
        out_res_r.vertex            <= s2_vtx_r;
        out_res_r.out_neighbours    <= s2_row_r;
        out_res_r.mutual_neighbours <= s2_mutual_r;
        out_res_r.out_degree        <= od_sum;
        out_res_r.in_degree         <= id_sum;
        out_res_r.has_loop          <= s2_loop_r;
        out_res_r.is_isolated       <= s2_iso_r;
        out_res_r.reaches_all       <= ({1'b0, od_sum} + 8'd1) >= {1'b0, vcount_r};
        out_res_r.last              <= s2_last_r;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept && is_edge && edge_ok) begin
            vcount_r <= vcount_nxt;
            state_r  <= ST_EDGE_WR;
          end else if (issue) begin
            idx_r   <= sweep_idx + AW'(1);
            state_r <= issue_last ? ST_DRAIN : ST_SWEEP;
          end
        end
        ST_EDGE_WR: begin
          // Write back the ORed row and column and mark them valid.
          row_vld_r[row_waddr_r] <= 1'b1;
          col_vld_r[col_waddr_r] <= 1'b1;
          state_r                <= ST_IDLE;
        end
        ST_SWEEP: begin
          idx_r <= sweep_idx + AW'(1);
          if (issue_last) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          // Hold busy until the last vertex has left the pipeline.
          if (!s1_vld_r && !s2_vld_r) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers: read capture, edge write-back and sweep pipeline.
  always_ff @(posedge clk) begin
    row_rvld_r <= row_vld_r[row_raddr];
    col_rvld_r <= col_vld_r[col_raddr];
    if (state_r == ST_IDLE) begin
      row_waddr_r <= src_m1[AW-1:0];
      col_waddr_r <= dst_m1[AW-1:0];
      row_bit_r   <= MAX_VERTICES'(1) << dst_m1[AW-1:0];
      col_bit_r   <= MAX_VERTICES'(1) << src_m1[AW-1:0];
    end
    s1_idx_r  <= sweep_idx;
    s1_last_r <= issue_last;
    if (s1_vld_r) begin
      s2_vtx_r    <= VTX_W'(s1_idx_r) + VTX_W'(1);
      s2_last_r   <= s1_last_r;
      s2_row_r    <= row64;
      s2_mutual_r <= row64 & col64 & ~self64;
      s2_loop_r   <= |(row64 & self64);
      s2_iso_r    <= (row64 == '0) && (col64 == '0);
      for (int g = 0; g < 8; g++) begin
        s2_rcnt_r[g] <= popcnt8(row64[g*8 +: 8]);
        s2_ccnt_r[g] <= popcnt8(col64[g*8 +: 8]);
      end
    end
  end

endmodule

`default_nettype wire

// ----- verif/digraph_adjacency_analyzer_unit_test.sv -----
// Self-checking test of the digraph adjacency analyzer: edge loads and analysis sweeps.
// Predicts every per-vertex report from its own copy of the adjacency matrix.
// Depends on daa_pkg and digraph_adjacency_analyzer_unit only.
`timescale 1ns / 100ps

module digraph_adjacency_analyzer_unit_test;
  import daa_pkg::*;

  localparam int MAXV = MAX_VERTICES_DEF;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  daa_req_t in_req = '0;
  logic     out_valid;
  daa_res_t out_res;

  digraph_adjacency_analyzer_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Requests waiting to be driven, and vertex reports the block still owes us.
  daa_req_t pending_reqs[$];
  daa_res_t reports_due[$];

  // Predicted graph: matrix kept by rows and by columns, plus highest vertex seen.
  logic [MAP_W-1:0] row_bits[MAXV];
  logic [MAP_W-1:0] col_bits[MAXV];
  int               vertex_total = 0;

  int idle_pct = 0;        // chance in percent that the driver skips a cycle
  bit req_taken = 1'b0;    // set at the edge that accepted the request on the bus
  int mismatch_count = 0;

  function automatic int count_ones(input logic [MAP_W-1:0] w);
    int n;
    n = 0;
    for (int i = 0; i < MAP_W; i++) n += w[i];
    return n;
  endfunction

  // Apply one accepted request to the predicted graph; an analysis queues one
  // report per vertex, lowest vertex first.
  task automatic predict_request(input daa_req_t r);
    int               s;
    int               d;
    int               od;
    daa_res_t         rep;
    logic [MAP_W-1:0] self_bit;
    if (r.req_type == REQ_ADD_EDGE) begin
      s = r.edge_src;
      d = r.edge_dst;
      // drop edges naming vertex 0 or anything past the limit
      if (s >= 1 && s <= MAXV && d >= 1 && d <= MAXV) begin
        row_bits[s-1][d-1] = 1'b1;
        col_bits[d-1][s-1] = 1'b1;
        if (s > vertex_total) vertex_total = s;
        if (d > vertex_total) vertex_total = d;
      end
    end else begin
      for (int v = 0; v < vertex_total; v++) begin
        self_bit              = '0;
        self_bit[v]           = 1'b1;
        od                    = count_ones(row_bits[v]);
        rep.vertex            = VTX_W'(v + 1);
        rep.out_neighbours    = row_bits[v];
        rep.mutual_neighbours = row_bits[v] & col_bits[v] & ~self_bit;
        rep.out_degree        = VTX_W'(od);
        rep.in_degree         = VTX_W'(count_ones(col_bits[v]));
        rep.has_loop          = row_bits[v][v];
        rep.is_isolated       = (row_bits[v] == '0) && (col_bits[v] == '0);
        rep.reaches_all       = (od + 1 >= vertex_total);
        rep.last              = (v + 1 == vertex_total);
        reports_due.push_back(rep);
      end
    end
  endtask

  task automatic show_report(input string tag, input daa_res_t r);
    $display("  %s v=%0d out=%h mut=%h od=%0d id=%0d loop=%b iso=%b all=%b last=%b",
             tag, r.vertex, r.out_neighbours, r.mutual_neighbours, r.out_degree,
             r.in_degree, r.has_loop, r.is_isolated, r.reaches_all, r.last);
  endtask

  // Monitor: sample at the rising edge. Record accepted requests first, then
  // match any strobed report against the oldest one owed.
  always @(posedge clk) begin
    daa_res_t want;
    if (rst_n) begin
      if (start && !busy) begin
        predict_request(in_req);
        req_taken = 1'b1;
      end
      if (out_valid) begin
        if (reports_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: report with none outstanding", $realtime);
            show_report("got", out_res);
          end
        end else begin
          want = reports_due.pop_front();
          if (out_res.vertex !== want.vertex ||
              out_res.out_neighbours !== want.out_neighbours ||
              out_res.mutual_neighbours !== want.mutual_neighbours ||
              out_res.out_degree !== want.out_degree ||
              out_res.in_degree !== want.in_degree ||
              out_res.has_loop !== want.has_loop ||
              out_res.is_isolated !== want.is_isolated ||
              out_res.reaches_all !== want.reaches_all ||
              out_res.last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: vertex report mismatch", $realtime);
              show_report("exp", want);
              show_report("got", out_res);
            end
          end
        end
      end
    end
  end

  // Driver: change inputs at the falling edge. Hold a request until it is taken,
  // then advance to the next one or idle.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || req_taken) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
        start  <= 1'b1;
        in_req <= pending_reqs.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
    req_taken = 1'b0;
  end

  task automatic queue_edge(input int s, input int d);
    daa_req_t r;
    r.req_type = REQ_ADD_EDGE;
    r.edge_src = VTX_W'(s);
    r.edge_dst = VTX_W'(d);
    pending_reqs.push_back(r);
  endtask

  // Analysis with junk in the edge fields, which the block must ignore.
  task automatic queue_analyze();
    daa_req_t r;
    r.req_type = REQ_ANALYZE;
    r.edge_src = VTX_W'($urandom);
    r.edge_dst = VTX_W'($urandom);
    pending_reqs.push_back(r);
  endtask

  function automatic int bad_vertex();
    return ($urandom_range(1) == 0) ? 0 : $urandom_range(MAXV + 1, 127);
  endfunction

  // Mostly good edges within 1..hi, some analyses, a few out-of-range edges.
  task automatic queue_random(input int hi, input int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 15)
        queue_analyze();
      else if (pick < 25)
        queue_edge(($urandom_range(1) == 0) ? bad_vertex() : $urandom_range(1, hi),
                   bad_vertex());
      else
        queue_edge($urandom_range(1, hi), $urandom_range(1, hi));
    end
  endtask

  task automatic drain_requests();
    wait (pending_reqs.size() == 0 && !start);
  endtask

  initial begin
    int v;
    int offset;
    for (int i = 0; i < MAXV; i++) begin
      row_bits[i] = '0;
      col_bits[i] = '0;
    end

    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: empty graph, bad edges, self loop on a lone vertex, two-way pair,
    // a duplicate, and an isolated vertex inside the vertex range.
    idle_pct = 0;
    queue_analyze();            // nothing loaded yet: no reports
    queue_edge(0, 1);
    queue_edge(1, 0);
    queue_edge(MAXV + 1, 1);
    queue_edge(127, 127);
    queue_edge(0, 0);
    queue_analyze();            // bad edges left the graph empty
    queue_edge(1, 1);
    queue_analyze();            // lone vertex always reaches all
    queue_edge(1, 2);
    queue_edge(2, 1);
    queue_edge(1, 2);           // duplicate
    queue_edge(4, 1);           // vertex 3 stays isolated
    queue_analyze();
    queue_random(6, 20);
    queue_analyze();
    drain_requests();

    // Sender idling about half the time, still a small graph.
    idle_pct = 49;
    queue_random(12, 20);
    queue_analyze();
    drain_requests();

    // Sparse idling; open up the full vertex range, corner vertex first.
    idle_pct = 23;
    queue_edge(MAXV, MAXV);
    queue_edge(MAXV, 1);
    queue_analyze();
    queue_random(MAXV, 20);
    drain_requests();

    // Back to back: fill one row so out-degree hits the vertex count.
    idle_pct = 0;
    v = $urandom_range(1, MAXV);
    offset = $urandom_range(MAXV - 1);
    for (int j = 0; j < MAXV; j++) queue_edge(v, (j + offset) % MAXV + 1);
    queue_edge(MAXV, v);
    queue_analyze();
    drain_requests();

    // Let the last edge write settle, collect all reports, then watch for strays.
    wait (reports_due.size() == 0);
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/daa_pkg.sv
rtl/core/daa_ram.sv
rtl/core/digraph_adjacency_analyzer_unit.sv
verif/digraph_adjacency_analyzer_unit_test.sv
